@@ sv/usds_pkg.sv @@
// Shared types, constants and helpers for the uniform sphere direction sampler.
package usds_pkg;

  // CORDIC gain of the infinite iteration, Q.32
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  // Width of the internal height and CORDIC datapath words
  localparam int H_W   = 33;   // signed Q.31 height
  localparam int CX_W  = 34;   // signed CORDIC x/y
  localparam int CZ_W  = 33;   // signed CORDIC residual angle, turns Q.32
  localparam int SAT_W = 36;   // input width of the Q1.15 rounding helper

  // Payload that travels alongside the datapath through every stage
  typedef struct packed {
    logic signed [H_W-1:0] h;     // height, Q.31
    logic [1:0]            quad;  // azimuth quadrant
    logic [29:0]           zres;  // azimuth below a quarter turn
  } side_t;

  // Arctangent of 2^-i in turns, Q.32, rounded to nearest
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      24:      a = 32'd41;
      25:      a = 32'd20;
      26:      a = 32'd10;
      27:      a = 32'd5;
      28:      a = 32'd3;
      29:      a = 32'd1;
      30:      a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Q.31 to Q1.15: add half an LSB, floor, saturate
  function automatic logic [15:0] sat_q15(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] t;
    logic [15:0]             r;
    t = (v + SAT_W'(32768)) >>> 16;
    if (t > SAT_W'(32767)) begin
      r = 16'h7fff;
    end else if (t < -SAT_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

@@ sv/uniform_sphere_direction_sampler_unit.sv @@
// Top level of the uniform sphere direction sampler pipeline.
//
// Turns a pair of uniform numbers (u_height, v_azimuth, unsigned Q0.SAMPLE_BITS)
// into a unit direction (dir_x, dir_height, dir_z) in signed Q1.15, height in
// the middle slot. hemisphere_mode selects the full sphere (height 1-2u) or the
// upper hemisphere (height u); it resets to hemisphere and should only be
// written while the pipeline is empty. The block is a fully pipelined datapath:
// one transaction is accepted every clock while the output is not stalled. The
// pipeline depth is set by the square root, which resolves one root bit per
// stage over 32 stages, plus one stage per CORDIC rotation, two multiplier
// stages (height squared, CORDIC gain), the input, clamp and output registers.
// A stall on a valid output freezes the whole pipeline; in_stall is raised in
// the same cycle, so nothing is dropped or duplicated. There is no start-up
// sweep after reset.
module uniform_sphere_direction_sampler_unit
  import usds_pkg::*;
#(
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic                   cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] u_height,
  input  logic [SAMPLE_BITS-1:0] v_azimuth,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            dir_x,
  output logic [15:0]            dir_height,
  output logic [15:0]            dir_z
);

  // Stage map:
  //   0                 input register, height formed
  //   1                 height squared (32x32 multiply)
  //   2                 1 - h^2 clamped at zero
  //   3 .. 34           square root, one bit per stage
  //   35                start vector r*K, rounded (32x32 multiply)
  //   36 .. 35+N        CORDIC rotations
  //   36+N              quadrant fold, rounding, output register
  localparam int ROOT_STEPS = 32;
  localparam int NSTG       = 37 + CORDIC_STEPS;
  localparam int CORD_BASE  = 35;

  logic                   hemisphere_mode;
  logic                   adv;
  logic [NSTG-1:0]        vld;
  side_t                  sd [0:NSTG-2];

  logic [31:0]            u_wide;
  logic [31:0]            v_wide;
  logic signed [H_W-1:0]  h_in;

  logic [31:0]            habs;
  logic [62:0]            hsq;

  logic [63:0]            rt_d    [0:ROOT_STEPS];
  logic [32:0]            rt_rem  [0:ROOT_STEPS];
  logic [31:0]            rt_root [0:ROOT_STEPS];

  logic [63:0]            gain_prod;

  logic signed [CX_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [CZ_W-1:0] cz [0:CORDIC_STEPS];

  logic signed [CX_W-1:0] ox;
  logic signed [CX_W-1:0] oz;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hemisphere_mode <= 1'b1;
    end else if (cfg_write) begin
      hemisphere_mode <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline moves together unless the output
  // register holds a transaction that the sink is stalling.
  // ---------------------------------------------------------------------------
  assign adv       = !vld[NSTG-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: widen inputs to Q0.32 and form the height in Q.31
  // ---------------------------------------------------------------------------
  assign u_wide = 32'(u_height) << (32 - SAMPLE_BITS);
  assign v_wide = 32'(v_azimuth) << (32 - SAMPLE_BITS);

  always_comb begin
    if (hemisphere_mode) begin
      h_in = H_W'({1'b0, u_wide[31:1]});
    end else begin
      // 1.0 - 2u with u in Q0.32: 2^31 - U in Q.31
      h_in = H_W'(33'h0_8000_0000) - H_W'({1'b0, u_wide});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0].h    <= h_in;
      sd[0].quad <= v_wide[31:30];
      sd[0].zres <= v_wide[29:0];
    end
  end

  // side payload just follows the pipeline
  for (genvar k = 1; k <= NSTG - 2; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: h squared. |h| <= 2^31, so the square fits in 63 bits.
  // ---------------------------------------------------------------------------
  assign habs = sd[0].h[H_W-1] ? 32'(-sd[0].h) : 32'(sd[0].h);

  always_ff @(posedge clk) begin
    if (adv) begin
      hsq <= {31'd0, habs} * {31'd0, habs};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: radicand 1 - h^2 in Q.62, clamped at zero (h = +-1 gives zero)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      rt_d[0]    <= hsq[62] ? 64'd0 : {1'b0, 63'h4000_0000_0000_0000 - hsq};
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3..34: restoring square root, two radicand bits in, one root bit
  // out per stage. The remainder never exceeds twice the root, so 33 bits.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        take;

    assign rem2  = {rt_rem[k], rt_d[k][63:62]};
    assign trial = 35'({rt_root[k], 2'b01});
    assign take  = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_d[k+1]    <= {rt_d[k][61:0], 2'b00};
        rt_rem[k+1]  <= take ? 33'(rem2 - trial) : rem2[32:0];
        rt_root[k+1] <= {rt_root[k][30:0], take};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 35: start vector (round(r*K), 0), residual angle from the azimuth
  // ---------------------------------------------------------------------------
  assign gain_prod = 64'(rt_root[ROOT_STEPS]) * 64'(GAIN_Q32) + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CX_W'({1'b0, gain_prod[63:32]});
      cy[0] <= '0;
      cz[0] <= CZ_W'({1'b0, sd[CORD_BASE-1].zres});
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotations, one per stage; shifts are arithmetic (floor).
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [CZ_W-1:0] ang;

    assign dx  = cy[i] >>> i;
    assign dy  = cx[i] >>> i;
    assign ang = CZ_W'(atan_turn(i));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][CZ_W-1]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ang;
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ang;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: fold the quadrant back in, round to Q1.15 and saturate
  // ---------------------------------------------------------------------------
  always_comb begin
    case (sd[NSTG-2].quad)
      2'd0: begin
        ox = cx[CORDIC_STEPS];
        oz = cy[CORDIC_STEPS];
      end
      2'd1: begin
        ox = -cy[CORDIC_STEPS];
        oz = cx[CORDIC_STEPS];
      end
      2'd2: begin
        ox = -cx[CORDIC_STEPS];
        oz = -cy[CORDIC_STEPS];
      end
      default: begin
        ox = cy[CORDIC_STEPS];
        oz = -cx[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x      <= sat_q15(SAT_W'(ox));
      dir_height <= sat_q15(SAT_W'(sd[NSTG-2].h));
      dir_z      <= sat_q15(SAT_W'(oz));
    end
  end

endmodule

@@ sv/usds_checker.sv @@
// Port-level checker for the sampler pipeline, with its bind.
module usds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] dir_x,
  input logic [15:0] dir_height,
  input logic [15:0] dir_z
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dir_x) && $stable(dir_height) && $stable(dir_z))
    else $error("result changed while stalled");

  // the pipeline holds its input exactly when the output transaction is held
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind uniform_sphere_direction_sampler_unit usds_checker u_usds_checker (.*);

@@ tb/uniform_sphere_direction_sampler_unit_test.sv @@
// Self-checking testbench for the uniform sphere direction sampler unit.
`timescale 1ns / 1ps

module uniform_sphere_direction_sampler_unit_test;

  // Register values of hemisphere_mode
  localparam bit MODE_SPHERE = 1'b0;   // height 1-2u
  localparam bit MODE_HEMI   = 1'b1;   // height u, reset value

  localparam int IDLE_PCT      = 19;    // chance in a hundred of an idle cycle, each side
  localparam int PHASES        = 6;     // random phases, alternating mode
  localparam int PHASE_ITEMS   = 105;   // random transactions per phase
  localparam int HOLD_CYCLES   = 240;   // long receiver hold-off, well past pipe depth
  localparam int DRAIN_CYCLES  = 4;     // settle time before a register write
  localparam int TAIL_CYCLES   = 70;    // wait after the last result, to catch any stray output
  localparam int ROTATIONS     = 16;    // CORDIC steps of the block
  localparam int WATCHDOG_NS   = 2_000_000;

  // CORDIC gain of the infinite iteration, Q.32
  localparam longint unsigned ROT_GAIN = 64'd2608131496;

  // atan(2^-i) in turns, Q.32
  localparam longint ATAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] height;
    logic [15:0] z;
  } dir_t;

  // Full sphere with u = 0: height saturates, ring radius is zero
  localparam dir_t NORTH_POLE = '{x: 16'h0000, height: 16'h7fff, z: 16'h0000};

  typedef struct packed {
    logic        mode;
    logic [15:0] u;
    logic [15:0] v;
    logic        known;   // want holds the answer, predictor not consulted
    dir_t        want;
  } probe_t;

  // Directed transactions: poles, equator, quadrant boundaries, field extremes
  localparam probe_t PROBES [22] = '{
    '{MODE_HEMI,   16'h0000, 16'h0000, 1'b0, '0},
    '{MODE_HEMI,   16'h0000, 16'h4000, 1'b0, '0},
    '{MODE_HEMI,   16'h0000, 16'h8000, 1'b0, '0},
    '{MODE_HEMI,   16'h0000, 16'hc000, 1'b0, '0},
    '{MODE_HEMI,   16'hffff, 16'h0000, 1'b0, '0},
    '{MODE_HEMI,   16'hffff, 16'hffff, 1'b0, '0},
    '{MODE_HEMI,   16'h8000, 16'h2000, 1'b0, '0},
    '{MODE_HEMI,   16'h0001, 16'h0001, 1'b0, '0},
    '{MODE_HEMI,   16'h7fff, 16'h3fff, 1'b0, '0},
    '{MODE_HEMI,   16'haaaa, 16'h5555, 1'b0, '0},
    '{MODE_HEMI,   16'h5555, 16'haaaa, 1'b0, '0},
    '{MODE_SPHERE, 16'h0000, 16'h0000, 1'b1, NORTH_POLE},
    '{MODE_SPHERE, 16'h0000, 16'hffff, 1'b1, NORTH_POLE},
    '{MODE_SPHERE, 16'h0000, 16'h9c3a, 1'b1, NORTH_POLE},
    '{MODE_SPHERE, 16'hffff, 16'h0000, 1'b0, '0},
    '{MODE_SPHERE, 16'h8000, 16'h0000, 1'b0, '0},
    '{MODE_SPHERE, 16'h8000, 16'h4000, 1'b0, '0},
    '{MODE_SPHERE, 16'h8000, 16'h8000, 1'b0, '0},
    '{MODE_SPHERE, 16'h8000, 16'hc000, 1'b0, '0},
    '{MODE_SPHERE, 16'h0001, 16'h7fff, 1'b0, '0},
    '{MODE_SPHERE, 16'h4000, 16'he000, 1'b0, '0},
    '{MODE_SPHERE, 16'hc000, 16'h2000, 1'b0, '0}
  };

  // Block inputs, all known from time zero
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_write  = 1'b0;
  logic        cfg_data   = 1'b0;
  logic        in_valid   = 1'b0;
  logic [15:0] u_height   = '0;
  logic [15:0] v_azimuth  = '0;
  logic        out_stall  = 1'b0;

  // Block outputs
  logic        in_stall;
  logic        out_valid;
  logic [15:0] dir_x;
  logic [15:0] dir_height;
  logic [15:0] dir_z;

  // Shared testbench state
  logic steady  = 1'b0;   // no idling on either side while set
  logic hold_rx = 1'b0;   // long output hold-off in progress
  bit   hold_arm = 1'b0;
  bit   cur_mode = MODE_HEMI;

  dir_t pending_dirs [$];
  int   sample_count   = 0;
  int   checked_count  = 0;
  int   mismatch_count = 0;
  int   mode_writes    = 0;

  uniform_sphere_direction_sampler_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .u_height   (u_height),
    .v_azimuth  (v_azimuth),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dir_x      (dir_x),
    .dir_height (dir_height),
    .dir_z      (dir_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Digit-by-digit floor square root of a Q.62 value, giving Q.31
  function automatic longint unsigned ring_root(input longint unsigned d);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem  = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((d >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // Q.31 to Q1.15, half-up rounding then saturation
  function automatic logic [15:0] round_q15(input longint v);
    longint t;
    t = (v + 64'sd32768) >>> 16;
    if (t > 64'sd32767) begin
      return 16'h7fff;
    end
    if (t < -64'sd32768) begin
      return 16'h8000;
    end
    return t[15:0];
  endfunction

  function automatic dir_t predict_direction(input bit mode, input logic [15:0] u,
                                             input logic [15:0] v);
    longint unsigned uq;
    longint unsigned vq;
    longint unsigned habs;
    longint unsigned hsq;
    longint unsigned radial;
    longint          h;
    longint          cx;
    longint          cy;
    longint          cz;
    longint          dx;
    longint          dy;
    longint          ox;
    longint          oz;
    logic [1:0]      quad;
    dir_t            d;

    uq = {32'b0, u, 16'b0};
    vq = {32'b0, v, 16'b0};

    if (mode == MODE_HEMI) begin
      h = longint'(uq >> 1);
    end else begin
      h = 64'sd2147483648 - longint'(uq);
    end

    // ring radius sqrt(1 - h^2), exact in Q.62 and clamped at zero
    habs   = (h < 0) ? longint'(-h) : h;
    hsq    = habs * habs;
    radial = (hsq >= 64'h4000_0000_0000_0000) ? 64'd0 : (64'h4000_0000_0000_0000 - hsq);

    cx   = longint'((ring_root(radial) * ROT_GAIN + 64'd2147483648) >> 32);
    cy   = 0;
    quad = vq[31:30];
    cz   = longint'(vq & 64'h3fff_ffff);

    // rotation mode, shifts floor towards minus infinity
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - ATAN_TURN[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + ATAN_TURN[i];
      end
    end

    case (quad)
      2'd0: begin
        ox = cx;
        oz = cy;
      end
      2'd1: begin
        ox = -cy;
        oz = cx;
      end
      2'd2: begin
        ox = -cx;
        oz = -cy;
      end
      default: begin
        ox = cy;
        oz = -cx;
      end
    endcase

    d.x      = round_q15(ox);
    d.height = round_q15(h);
    d.z      = round_q15(oz);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one transaction and holds it until accepted; random idle gap first.
  task automatic send_sample(input logic [15:0] u, input logic [15:0] v,
                             input bit known, input dir_t want);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid  <= 1'b1;
    u_height  <= u;
    v_azimuth <= v;
    do @(posedge clk); while (in_stall);
    pending_dirs = {pending_dirs, (known ? want : predict_direction(cur_mode, u, v))};
    sample_count++;
  endtask

  // Register write with the pipe empty
  task automatic write_mode(input bit m);
    in_valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  // Uniform most of the time, with a bias to values on the boundaries
  function automatic logic [15:0] pick_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       return 16'h0000;
        1:       return 16'h0001;
        2:       return 16'h3fff;
        3:       return 16'h4000;
        4:       return 16'h8000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Random stalls, none while steady, solid during the hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_rx || (!steady && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Long hold-off: solid output stall that freezes the pipe once a result reaches the output
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Scoreboard: every accepted result against the oldest expectation
  always @(posedge clk) begin
    dir_t got;
    dir_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{x: dir_x, height: dir_height, z: dir_z};
      if (pending_dirs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result x=%0d h=%0d z=%0d", $realtime,
                   $signed(got.x), $signed(got.height), $signed(got.z));
        end
      end else begin
        want = pending_dirs.pop_front();
        checked_count++;
        if (got.x !== want.x || got.height !== want.height || got.z !== want.z) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result %0d expected x=%0d h=%0d z=%0d got x=%0d h=%0d z=%0d",
                     $realtime, checked_count,
                     $signed(want.x), $signed(want.height), $signed(want.z),
                     $signed(got.x), $signed(got.height), $signed(got.z));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: mode changes only where the table switches it
    foreach (PROBES[n]) begin
      if (PROBES[n].mode != cur_mode) begin
        write_mode(PROBES[n].mode);
      end
      send_sample(PROBES[n].u, PROBES[n].v, PROBES[n].known, PROBES[n].want);
    end

    // Random phases; phases 2 and 3 run flat out, 3 also carries the hold-off
    for (int p = 0; p < PHASES; p++) begin
      write_mode((p % 2 == 0) ? MODE_HEMI : MODE_SPHERE);
      steady <= (p == 2 || p == 3);
      if (p == 3) begin
        hold_arm = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        send_sample(pick_sample(), pick_sample(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions, %0d results checked, %0d mode writes",
             sample_count, checked_count, mode_writes);
    $display("in both modes, with random idling, a flat-out stretch and a long output hold-off");
    if (mismatch_count == 0 && pending_dirs.size() == 0) begin
      $display("[uniform_sphere_direction_sampler_unit] OK");
    end else begin
      $display("[uniform_sphere_direction_sampler_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("[uniform_sphere_direction_sampler_unit] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/usds_pkg.sv
sv/uniform_sphere_direction_sampler_unit.sv
sv/usds_checker.sv
tb/uniform_sphere_direction_sampler_unit_test.sv
